// File: hdl/svd_pkg.sv
package svd_pkg;

	localparam int CONSTRAINT_LENGTH = 7;
	localparam int TRACE_DEPTH = 64;
	localparam int METRIC_W = 32;
	localparam logic [31:0] METRIC_INIT = 32'd1000;
	localparam logic [9:0] BM_SUM = 10'd510;
	localparam logic [7:0] SYM_ONE = 8'd255;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_STEP = 2'd0,
		OP_DECODE = 2'd1,
		OP_INIT = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// One input item.
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] soft_first;
		logic [7:0] soft_second;
		logic [6:0] trace_delay;
		logic [5:0] end_state;
		logic find_best;
		logic [5:0] start_state;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic decoded_bit;
		logic bit_valid;
	} out_item_t;

	// Configuration register addresses.
	localparam logic [1:0] REG_GEN_FIRST = 2'd0;
	localparam logic [1:0] REG_GEN_SECOND = 2'd1;
	localparam logic [1:0] REG_INV_FIRST = 2'd2;
	localparam logic [1:0] REG_INV_SECOND = 2'd3;

	typedef struct packed {
		logic [6:0] gen_first;
		logic [6:0] gen_second;
		logic inv_first;
		logic inv_second;
	} cfg_t;

endpackage

// File: hdl/soft_viterbi_rate_half_decoder_top.sv
// Rate-1/2 soft-decision Viterbi decoder. Items enter on start when busy is
// low and wait in a two-entry queue; the sequencer takes the oldest item
// when it is idle and runs items one at a time. A symbol-pair step computes
// the butterflies one after another through the metric memories. A decode
// searches all states for the best metric when find_best is set, else
// starts from the given end state, then walks back one step per step of
// traceback delay. A decode gives one result on done for one cycle; the
// receiver cannot stall it, so it must take every strobe. The user must
// write registers only while no item is in flight; the block itself does
// not enforce this.
module soft_viterbi_rate_half_decoder_top #(
	parameter int CONSTRAINT_LENGTH = svd_pkg::CONSTRAINT_LENGTH,
	parameter int TRACE_DEPTH = svd_pkg::TRACE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input svd_pkg::in_item_t in_item,
	output logic done,
	output svd_pkg::out_item_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	svd_pkg::cfg_t cfg_q;
	logic pop, q_valid;
	svd_pkg::in_item_t q_item;

	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				svd_pkg::REG_GEN_FIRST: cfg_q.gen_first <= pwdata[6:0];
				svd_pkg::REG_GEN_SECOND: cfg_q.gen_second <= pwdata[6:0];
				svd_pkg::REG_INV_FIRST: cfg_q.inv_first <= pwdata[0];
				svd_pkg::REG_INV_SECOND: cfg_q.inv_second <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			svd_pkg::REG_GEN_FIRST: prdata = {25'd0, cfg_q.gen_first};
			svd_pkg::REG_GEN_SECOND: prdata = {25'd0, cfg_q.gen_second};
			svd_pkg::REG_INV_FIRST: prdata = {31'd0, cfg_q.inv_first};
			svd_pkg::REG_INV_SECOND: prdata = {31'd0, cfg_q.inv_second};
			default: prdata = '0;
		endcase
	end

	svd_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item), .busy(busy),
		.pop(pop), .q_valid(q_valid), .q_item(q_item)
	);

	svd_back #(.K(CONSTRAINT_LENGTH), .DEPTH(TRACE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_item(q_item),
		.pop(pop), .done(done), .result(result)
	);

endmodule

// File: hdl/svd_ram.sv
module svd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/svd_front.sv
module svd_front #(
	parameter int QDEPTH = svd_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input svd_pkg::in_item_t in_item,
	output logic busy,
	input logic pop,
	output logic q_valid,
	output svd_pkg::in_item_t q_item
);

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	svd_pkg::in_item_t buf_q [QDEPTH];
	logic [AW-1:0] rd_q, wr_q;
	logic [AW:0] cnt_q;
	logic push;

	// Unused operation codes are dropped at the door.
	assign busy = (cnt_q == (AW+1)'(QDEPTH));
	assign push = start && !busy && (in_item.operation != svd_pkg::OP_NONE);
	assign q_valid = (cnt_q != '0);
	assign q_item = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: hdl/svd_back.sv
module svd_back #(
	parameter int K = svd_pkg::CONSTRAINT_LENGTH,
	parameter int DEPTH = svd_pkg::TRACE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input svd_pkg::cfg_t cfg,
	input logic q_valid,
	input svd_pkg::in_item_t q_item,
	output logic pop,
	output logic done,
	output svd_pkg::out_item_t result
);

	localparam int NS = 1 << (K-1);
	localparam int HS = 1 << (K-2);
	localparam int SW = K-1;
	localparam int HW = (K-2 > 0) ? K-2 : 1;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW = svd_pkg::METRIC_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_ACS_RD, ST_ACS, ST_ACS_WR,
		ST_BEST, ST_TB_RD, ST_TB, ST_OUT
	} state_t;

	state_t state_q;
	svd_pkg::in_item_t item_q;
	logic bank_q;
	logic [PW-1:0] wpos_q, pos_q;
	logic [SW:0] idx_q;
	logic [6:0] delay_q;
	logic [SW-1:0] st_q;
	logic [MW-1:0] minm_q;
	logic [NS-1:0] dec_q;
	logic [NS-1:0] valid_a_q;
	logic first_q;
	logic [SW-1:0] st_init_q;
	logic [SW-1:0] end_best_q;

	// Metric memories: two banks, each kept as two identical copies so one
	// butterfly reads both of its old states, i and i+HS, in the same cycle. The
	// two new states of a butterfly go into both copies of the other bank one
	// per cycle: the even one while the butterfly is computed, the odd one in
	// the cycle after.
	logic [MW-1:0] lo_a_rd, hi_a_rd, lo_b_rd, hi_b_rd;
	logic [MW-1:0] a0_rd, a1_rd, b0_rd, b1_rd;
	logic [HW-1:0] rd_i;
	logic we_a, we_b;
	logic [MW-1:0] m_new1_q;
	logic [HW-1:0] wi_q;
	logic pending_q;
	logic [SW-1:0] ra0, ra1, wa;
	logic [MW-1:0] wd;

	svd_ram #(.WIDTH(MW), .DEPTH(NS)) u_a0 (.clk(clk), .we(we_a), .waddr(wa),
		.wdata(wd), .raddr(ra0), .rdata(lo_a_rd));
	svd_ram #(.WIDTH(MW), .DEPTH(NS)) u_a1 (.clk(clk), .we(we_a), .waddr(wa),
		.wdata(wd), .raddr(ra1), .rdata(hi_a_rd));
	svd_ram #(.WIDTH(MW), .DEPTH(NS)) u_b0 (.clk(clk), .we(we_b), .waddr(wa),
		.wdata(wd), .raddr(ra0), .rdata(lo_b_rd));
	svd_ram #(.WIDTH(MW), .DEPTH(NS)) u_b1 (.clk(clk), .we(we_b), .waddr(wa),
		.wdata(wd), .raddr(ra1), .rdata(hi_b_rd));

	logic [SW-1:0] rs0, rs1;
	logic [SW-1:0] rd_addr_q;

	// Read state pair for butterfly i: i on copy 0 and i+HS on copy 1.
	assign rs0 = SW'(rd_i);
	assign rs1 = SW'(rd_i) | SW'(HS);
	// The best-state search and the traceback start read one state on copy 0.
	assign ra0 = (state_q == ST_BEST || state_q == ST_TB_RD) ? st_q : rs0;
	assign ra1 = rs1;

	assign a0_rd = lo_a_rd;
	assign a1_rd = hi_a_rd;
	assign b0_rd = lo_b_rd;
	assign b1_rd = hi_b_rd;

	// Old metrics, with bank a entries reading as reset value before written.
	logic [MW-1:0] old0, old1;
	logic v0, v1;
	logic [SW-1:0] rd_addr1_q;
	assign v0 = valid_a_q[rd_addr_q];
	assign v1 = valid_a_q[rd_addr1_q];
	always_comb begin
		if (bank_q) begin
			old0 = b0_rd;
			old1 = b1_rd;
		end else begin
			old0 = v0 ? a0_rd : ((rd_addr_q == st_init_q) ? '0 : svd_pkg::METRIC_INIT);
			old1 = v1 ? a1_rd : ((rd_addr1_q == st_init_q) ? '0 : svd_pkg::METRIC_INIT);
		end
	end

	// Branch metric for butterfly i.
	logic [HW-1:0] bi;
	logic e1, e2;
	logic [7:0] x1, x2;
	logic [9:0] bm, bmc;
	logic [MW-1:0] m0, m1, m2, m3, d01, d23;
	logic dd0, dd1;
	assign bi = rd_addr_q[HW-1:0];
	assign e1 = cfg.inv_first ^ (^(7'({bi, 1'b0}) & cfg.gen_first));
	assign e2 = cfg.inv_second ^ (^(7'({bi, 1'b0}) & cfg.gen_second));
	assign x1 = (e1 ? svd_pkg::SYM_ONE : 8'd0) ^ item_q.soft_first;
	assign x2 = (e2 ? svd_pkg::SYM_ONE : 8'd0) ^ item_q.soft_second;
	assign bm = 10'(x1) + 10'(x2);
	assign bmc = svd_pkg::BM_SUM - bm;
	assign m0 = old0 + MW'(bm);
	assign m1 = old1 + MW'(bmc);
	assign m2 = old0 + MW'(bmc);
	assign m3 = old1 + MW'(bm);
	assign d01 = m0 - m1;
	assign d23 = m2 - m3;
	assign dd0 = !d01[MW-1];
	assign dd1 = !d23[MW-1];

	// New metrics go to both copies of the bank that is not the old one.
	logic wr_now;
	assign wr_now = pending_q || (state_q == ST_ACS);
	assign wa = pending_q ? {wi_q, 1'b1} : {bi, 1'b0};
	assign wd = pending_q ? m_new1_q : (dd0 ? m1 : m0);
	assign we_a = wr_now && bank_q;
	assign we_b = wr_now && !bank_q;

	// Decision store.
	logic dec_we;
	logic [NS-1:0] dec_rd;
	logic [PW-1:0] dec_ra;
	assign dec_ra = (pos_q == '0) ? PW'(DEPTH-1) : pos_q - 1'b1;
	svd_ram #(.WIDTH(NS), .DEPTH(DEPTH)) u_dec (.clk(clk), .we(dec_we), .waddr(wpos_q),
		.wdata(dec_q), .raddr(dec_ra), .rdata(dec_rd));

	logic [MW-1:0] cur_m;
	assign cur_m = old0;
	logic [SW-1:0] next_st;
	logic tb_bit;
	assign tb_bit = dec_rd[st_q];
	assign next_st = {tb_bit, st_q[SW-1:1]};

	assign pop = (state_q == ST_IDLE) && q_valid;
	assign rd_i = idx_q[HW-1:0];

	// Sequencer: butterflies one at a time for a step, a best-state search when asked and a traceback for a decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bank_q <= 1'b0;
			wpos_q <= '0;
			valid_a_q <= '0;
			st_init_q <= '0;
			done <= 1'b0;
			pending_q <= 1'b0;
			dec_we <= 1'b0;
		end else begin
			done <= 1'b0;
			dec_we <= 1'b0;
			pending_q <= 1'b0;
			if (wr_now && bank_q) begin
				valid_a_q[wa] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						idx_q <= '0;
						case (svd_pkg::op_t'(q_item.operation))
							svd_pkg::OP_STEP: state_q <= ST_ACS_RD;
							svd_pkg::OP_DECODE: state_q <= ST_BEST;
							svd_pkg::OP_INIT: state_q <= ST_INIT;
							default: state_q <= ST_IDLE;
						endcase
						st_q <= '0;
						first_q <= 1'b1;
						pos_q <= wpos_q;
						delay_q <= q_item.trace_delay;
						dec_q <= '0;
					end
				end
				ST_INIT: begin
					valid_a_q <= '0;
					st_init_q <= SW'(item_q.start_state);
					bank_q <= 1'b0;
					wpos_q <= '0;
					state_q <= ST_IDLE;
				end
				ST_ACS_RD: begin
					rd_addr_q <= rs0;
					rd_addr1_q <= rs1;
					idx_q <= idx_q + 1'b1;
					state_q <= ST_ACS;
				end
				ST_ACS: begin
					m_new1_q <= dd1 ? m3 : m2;
					wi_q <= bi;
					pending_q <= 1'b1;
					dec_q[{bi, 1'b0}] <= dd0;
					dec_q[{bi, 1'b1}] <= dd1;
					if (idx_q == (SW+1)'(HS)) begin
						state_q <= ST_ACS_WR;
					end else begin
						state_q <= ST_ACS_RD;
					end
				end
				ST_ACS_WR: begin
					dec_we <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_BEST: begin
					// Reads of state st_q settle in the next cycle.
					rd_addr_q <= st_q;
					rd_addr1_q <= st_q;
					if (!item_q.find_best) begin
						st_q <= SW'(item_q.end_state);
						state_q <= ST_TB_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (idx_q != '0) begin
							if (first_q || cur_m < minm_q) begin
								minm_q <= cur_m;
								end_best_q <= rd_addr_q;
							end
							first_q <= 1'b0;
						end
						if (idx_q == (SW+1)'(NS)) begin
							state_q <= ST_TB_RD;
						end else begin
							st_q <= idx_q[SW-1:0] + 1'b1;
						end
					end
				end
				ST_TB_RD: begin
					if (item_q.find_best && idx_q != '0) begin
						st_q <= end_best_q;
						idx_q <= '0;
					end
					pos_q <= dec_ra;
					if (delay_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_TB;
					end
				end
				ST_TB: begin
					result.decoded_bit <= tb_bit;
					st_q <= next_st;
					pos_q <= dec_ra;
					delay_q <= delay_q - 1'b1;
					state_q <= (delay_q == 7'd1) ? ST_OUT : ST_TB;
				end
				ST_OUT: begin
					if (item_q.operation == svd_pkg::OP_STEP) begin
						wpos_q <= (wpos_q == PW'(DEPTH-1)) ? '0 : wpos_q + 1'b1;
						bank_q <= !bank_q;
					end else begin
						done <= 1'b1;
						result.bit_valid <= (item_q.trace_delay != '0);
						if (item_q.trace_delay == '0) begin
							result.decoded_bit <= 1'b0;
						end
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: tb/tb_soft_viterbi_rate_half_decoder_top.sv
`timescale 1ns / 1ps

// Reference predictor plus a queue of the decode results still to arrive.
class viterbi_scoreboard;
	bit [6:0] gen_a, gen_b;
	bit inv_a, inv_b;
	bit [31:0] old_metric [64];
	bit [63:0] decisions [64];
	bit [5:0] wr_pos;
	svd_pkg::out_item_t pending [$];
	int errors;

	function new();
		errors = 0;
		gen_a = '0;
		gen_b = '0;
		inv_a = 1'b0;
		inv_b = 1'b0;
		foreach (decisions[i]) decisions[i] = '0;
		restart_frame(6'd0);
	endfunction

	function void restart_frame(bit [5:0] st);
		foreach (old_metric[i]) old_metric[i] = svd_pkg::METRIC_INIT;
		old_metric[st] = '0;
		wr_pos = '0;
	endfunction

	function void write_reg(bit [1:0] idx, bit [31:0] val);
		case (idx)
			svd_pkg::REG_GEN_FIRST: gen_a = val[6:0];
			svd_pkg::REG_GEN_SECOND: gen_b = val[6:0];
			svd_pkg::REG_INV_FIRST: inv_a = val[0];
			default: inv_b = val[0];
		endcase
	endfunction

	// Add-compare-select over all state pairs.
	function void run_acs(bit [7:0] s1, bit [7:0] s2);
		bit [31:0] fresh [64];
		bit [63:0] row;
		bit [31:0] bm, m0, m1, m2, m3, d01, d23;
		bit [7:0] e1, e2;
		row = '0;
		for (int i = 0; i < 32; i++) begin
			e1 = (inv_a ^ (^(7'(2 * i) & gen_a))) ? svd_pkg::SYM_ONE : 8'd0;
			e2 = (inv_b ^ (^(7'(2 * i) & gen_b))) ? svd_pkg::SYM_ONE : 8'd0;
			bm = 32'(e1 ^ s1) + 32'(e2 ^ s2);
			m0 = old_metric[i] + bm;
			m1 = old_metric[i + 32] + (32'd510 - bm);
			m2 = old_metric[i] + (32'd510 - bm);
			m3 = old_metric[i + 32] + bm;
			d01 = m0 - m1;
			d23 = m2 - m3;
			row[2 * i] = !d01[31];
			row[2 * i + 1] = !d23[31];
			fresh[2 * i] = !d01[31] ? m1 : m0;
			fresh[2 * i + 1] = !d23[31] ? m3 : m2;
		end
		old_metric = fresh;
		decisions[wr_pos] = row;
		wr_pos++;
	endfunction

	function void note_item(svd_pkg::in_item_t it);
		svd_pkg::out_item_t r;
		bit [5:0] st, pos;
		bit [31:0] best;
		bit b;
		case (svd_pkg::op_t'(it.operation))
			svd_pkg::OP_STEP: run_acs(it.soft_first, it.soft_second);
			svd_pkg::OP_INIT: restart_frame(it.start_state);
			svd_pkg::OP_DECODE: begin
				st = it.end_state;
				if (it.find_best) begin
					st = '0;
					best = old_metric[0];
					for (int i = 1; i < 64; i++)
						if (old_metric[i] < best) begin
							best = old_metric[i];
							st = 6'(i);
						end
				end
				pos = wr_pos;
				b = 1'b0;
				for (int k = 0; k < it.trace_delay; k++) begin
					pos--;
					b = decisions[pos][st];
					st = {b, st[5:1]};
				end
				r.decoded_bit = b;
				r.bit_valid = (it.trace_delay != '0);
				pending.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function void check_result(svd_pkg::out_item_t got);
		svd_pkg::out_item_t want;
		if (pending.size() == 0) begin
			$error("unexpected result %b", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.decoded_bit !== want.decoded_bit) begin
			$error("decoded_bit expected %b actual %b", want.decoded_bit, got.decoded_bit);
			errors++;
		end
		if (got.bit_valid !== want.bit_valid) begin
			$error("bit_valid expected %b actual %b", want.bit_valid, got.bit_valid);
			errors++;
		end
	endfunction
endclass

module tb_soft_viterbi_rate_half_decoder_top;
	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	svd_pkg::in_item_t in_item = '0;
	logic done;
	svd_pkg::out_item_t result;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	bit quiet = 0;
	int steps_since_init;
	viterbi_scoreboard sb = new();

	soft_viterbi_rate_half_decoder_top dut (.*);

	always #2 clk = ~clk;

	// Results are taken at the edge that ends the strobe cycle.
	always @(posedge clk)
		if (arst_n && done) sb.check_result(result);

	// Setup phase, access phase, then the bus goes idle.
	task automatic write_reg(bit [1:0] idx, bit [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// Start stays high after an item is taken until the next call or drain drives it.
	task automatic send(svd_pkg::in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1;
		in_item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
		if (it.operation == svd_pkg::OP_STEP && steps_since_init < 64) steps_since_init++;
		if (it.operation == svd_pkg::OP_INIT) steps_since_init = 0;
	endtask

	// Wait for all results, then give the queued steps time to finish.
	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic svd_pkg::in_item_t rand_item(bit [1:0] op);
		svd_pkg::in_item_t it;
		it = '0;
		it.operation = op;
		it.soft_first = 8'($urandom);
		it.soft_second = 8'($urandom);
		it.end_state = 6'($urandom);
		it.find_best = 1'($urandom);
		it.start_state = 6'($urandom);
		// Never walk back to a word not written since the last frame start.
		it.trace_delay = (steps_since_init >= 64) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(0, steps_since_init));
		return it;
	endfunction

	function automatic svd_pkg::in_item_t mk(bit [1:0] op, bit [7:0] a, bit [7:0] b,
			bit [6:0] d, bit [5:0] e, bit f, bit [5:0] s);
		svd_pkg::in_item_t it;
		it = '{op, a, b, d, e, f, s};
		return it;
	endfunction

	initial begin
		int r;
		steps_since_init = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed part: standard code, extremes of the symbols and delays.
		write_reg(svd_pkg::REG_GEN_FIRST, 32'h4F);
		write_reg(svd_pkg::REG_GEN_SECOND, 32'h6D);
		write_reg(svd_pkg::REG_INV_FIRST, 0);
		write_reg(svd_pkg::REG_INV_SECOND, 1);
		send(mk(svd_pkg::OP_INIT, 0, 0, 0, 0, 0, 6'd63));
		send(mk(svd_pkg::OP_STEP, 0, 255, 0, 0, 0, 0));
		send(mk(svd_pkg::OP_STEP, 255, 0, 0, 0, 0, 0));
		send(mk(svd_pkg::OP_STEP, 255, 255, 0, 0, 0, 0));
		send(mk(svd_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
		send(mk(svd_pkg::OP_NONE, 8'hFF, 8'hFF, 7'h7F, 6'h3F, 1, 6'h3F));
		send(mk(svd_pkg::OP_DECODE, 0, 0, 0, 6'd5, 1, 0));
		send(mk(svd_pkg::OP_DECODE, 0, 0, 4, 6'd63, 0, 0));
		send(mk(svd_pkg::OP_DECODE, 0, 0, 4, 0, 1, 0));
		steps_since_init = 4;
		for (int i = 0; i < 62; i++) send(rand_item(svd_pkg::OP_STEP));
		send(mk(svd_pkg::OP_DECODE, 0, 0, 7'd64, 6'd21, 0, 0));
		send(mk(svd_pkg::OP_DECODE, 0, 0, 7'd127, 0, 1, 0));
		send(mk(svd_pkg::OP_DECODE, 0, 0, 7'd1, 6'd42, 0, 0));
		// Random phases over several register settings, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(svd_pkg::REG_GEN_FIRST, 0);
					write_reg(svd_pkg::REG_GEN_SECOND, 0);
					write_reg(svd_pkg::REG_INV_FIRST, 0);
					write_reg(svd_pkg::REG_INV_SECOND, 0);
				end
				1: begin
					write_reg(svd_pkg::REG_GEN_FIRST, 127);
					write_reg(svd_pkg::REG_GEN_SECOND, 127);
					write_reg(svd_pkg::REG_INV_FIRST, 1);
					write_reg(svd_pkg::REG_INV_SECOND, 1);
				end
				default: begin
					write_reg(svd_pkg::REG_GEN_FIRST, $urandom);
					write_reg(svd_pkg::REG_GEN_SECOND, $urandom);
					write_reg(svd_pkg::REG_INV_FIRST, $urandom);
					write_reg(svd_pkg::REG_INV_SECOND, $urandom);
				end
			endcase
			if (ph == 4) quiet = 1;
			for (int n = 0; n < 115; n++) begin
				r = $urandom_range(0, 99);
				if (r < 60) send(rand_item(svd_pkg::OP_STEP));
				else if (r < 92) send(rand_item(svd_pkg::OP_DECODE));
				else if (r < 97) send(rand_item(svd_pkg::OP_INIT));
				else send(rand_item(svd_pkg::OP_NONE));
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("soft_viterbi_rate_half_decoder_top regression: pass");
		else
			$display("soft_viterbi_rate_half_decoder_top regression: fail");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("soft_viterbi_rate_half_decoder_top regression: fail");
		$finish;
	end
endmodule

// File: filelist.f
hdl/svd_pkg.sv
hdl/svd_ram.sv
hdl/svd_front.sv
hdl/svd_back.sv
hdl/soft_viterbi_rate_half_decoder_top.sv
tb/tb_soft_viterbi_rate_half_decoder_top.sv
